// ----- hw/rtl/tsb_pkg.sv -----
package tsb_pkg;

  localparam int HALF_WIDTH   = 256;
  localparam int ROWS         = 256;
  localparam int MAX_SPRITE   = 32;
  localparam int SAVE_DEPTH   = 1024;
  localparam int STRIDE_BYTES = 2 * HALF_WIDTH;
  localparam int STRIDE_SHIFT = $clog2(STRIDE_BYTES);
  localparam int FRAME_BYTES  = STRIDE_BYTES * ROWS;
  localparam int FRAME_AW     = $clog2(FRAME_BYTES);
  localparam int SAVE_AW      = $clog2(SAVE_DEPTH);
  localparam logic [7:0] SHIELD_LIMIT = 8'd224;

  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_READ   = 3'd1,
    KIND_BEGIN  = 3'd2,
    KIND_PIXEL  = 3'd3,
    KIND_UNDRAW = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX,
    S_UNDRAW,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [FRAME_AW-1:0] address;
    logic [8:0]          origin_x;
    logic [7:0]          origin_y;
    logic [5:0]          sprite_width;
    logic [5:0]          sprite_height;
    logic [7:0]          pixel;
    logic                shield;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] crash_level;
    logic       sprite_done;
    logic       error;
  } result_t;

  typedef struct packed {
    logic                re;
    logic                we;
    logic [FRAME_AW-1:0] addr;
    logic [7:0]          wdata;
  } frame_req_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [SAVE_AW-1:0] addr;
    logic [7:0]         wdata;
  } save_req_t;

  function automatic logic size_ok(input logic [5:0] w, input logic [5:0] h);
    logic [12:0] area;
    area = 13'(w) * 13'(h);
    return (w != 6'd0) && (h != 6'd0) && (7'(w) <= 7'(MAX_SPRITE)) &&
           (7'(h) <= 7'(MAX_SPRITE)) && (area <= 13'(SAVE_DEPTH));
  endfunction

  // row stride is a power of two, so the frame wrap is a truncation
  function automatic logic [FRAME_AW-1:0] cell_addr(input logic [7:0] row,
                                                    input logic [8:0] x,
                                                    input logic [5:0] col);
    logic [FRAME_AW+1:0] sum;
    sum = ((FRAME_AW+2)'(row) << STRIDE_SHIFT) + (FRAME_AW+2)'(x) + (FRAME_AW+2)'(col);
    return sum[FRAME_AW-1:0];
  endfunction

  function automatic logic [7:0] next_row(input logic [7:0] row);
    return (11'(row) >= 11'(ROWS - 1)) ? 8'd0 : row + 8'd1;
  endfunction

endpackage

// ----- hw/rtl/tsb_frame_ram.sv -----
module tsb_frame_ram (
  input  logic              clk,
  input  tsb_pkg::frame_req_t req,
  output logic [7:0]        rdata
);
  import tsb_pkg::*;

  logic [7:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ----- hw/rtl/tsb_save_ram.sv -----
module tsb_save_ram (
  input  logic             clk,
  input  tsb_pkg::save_req_t req,
  output logic [7:0]       rdata
);
  import tsb_pkg::*;

  logic [7:0] mem [SAVE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ----- hw/rtl/tsb_ctrl.sv -----
module tsb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsb_pkg::item_t      item,
  input  logic                slot_free,
  output logic                res_valid,
  output tsb_pkg::result_t    res,
  output tsb_pkg::frame_req_t frame_req,
  input  logic [7:0]          frame_rdata,
  output tsb_pkg::save_req_t  save_req,
  input  logic [7:0]          save_rdata
);
  import tsb_pkg::*;

  state_t state, state_next;

  // draw state
  logic                drawing;
  logic [8:0]          base_x;
  logic [7:0]          row_cursor;
  logic [5:0]          column_count;
  logic [10:0]         pixel_count;
  logic [5:0]          size_w;
  logic [11:0]         area;
  logic [7:0]          hit_max;
  logic                shield_on;

  // current request
  logic [2:0]          kind_q;
  logic [7:0]          pix_q;
  logic [FRAME_AW-1:0] pix_addr_q;
  logic                err_q;
  logic                done_q;

  // undraw walker
  logic [7:0]          u_row;
  logic [8:0]          u_x;
  logic [5:0]          u_w;
  logic [5:0]          u_h;
  logic [5:0]          u_col;
  logic [5:0]          u_rows;
  logic [SAVE_AW-1:0]  u_idx;
  logic                wr_pending;
  logic [FRAME_AW-1:0] wr_addr;

  logic                accept;
  logic                pix_ok;
  logic                item_size_ok;
  logic [FRAME_AW-1:0] pix_addr;
  logic                hit;
  logic [7:0]          hit_max_next;
  logic                pix_last;
  logic                col_wrap;
  logic                last_issue;

  assign in_stall     = rst || (state != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign pix_ok       = drawing && (pixel_count < 11'(SAVE_DEPTH));
  assign item_size_ok = size_ok(item.sprite_width, item.sprite_height);
  assign pix_addr     = cell_addr(row_cursor, base_x, column_count);

  // collision: nonzero saved byte under a nonzero pixel; with shield on, bytes at or above SHIELD_LIMIT do not count
  assign hit = (pix_q != 8'd0) && (frame_rdata > hit_max) &&
               (!shield_on || (frame_rdata < SHIELD_LIMIT));
  assign hit_max_next = hit ? frame_rdata : hit_max;
  assign pix_last     = (12'(pixel_count) + 12'd1) >= area;
  assign col_wrap     = (7'(column_count) + 7'd1) >= 7'(size_w);
  assign last_issue   = (u_col == u_w - 6'd1) && (u_rows == u_h - 6'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            KIND_PIXEL:  state_next = pix_ok ? S_PIX : S_DONE;
            KIND_UNDRAW: state_next = item_size_ok ? S_UNDRAW : S_DONE;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_PIX:    state_next = slot_free ? S_IDLE : S_DONE;
      S_UNDRAW: state_next = last_issue ? S_DRAIN : S_UNDRAW;
      S_DRAIN:  state_next = slot_free ? S_IDLE : S_DONE;
      S_DONE:   state_next = slot_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    frame_req = '0;
    save_req  = '0;
    res_valid = 1'b0;
    res       = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            KIND_WRITE: begin
              frame_req.we    = 1'b1;
              frame_req.addr  = item.address;
              frame_req.wdata = item.pixel;
            end
            KIND_READ: begin
              frame_req.re   = 1'b1;
              frame_req.addr = item.address;
            end
            KIND_PIXEL: begin
              frame_req.re   = pix_ok;
              frame_req.addr = pix_addr;
            end
            default: ;
          endcase
        end
      end
      S_PIX: begin
        frame_req.we    = (pix_q != 8'd0);
        frame_req.addr  = pix_addr_q;
        frame_req.wdata = pix_q;
        save_req.we     = 1'b1;
        save_req.addr   = pixel_count[SAVE_AW-1:0];
        save_req.wdata  = frame_rdata;
        res_valid       = slot_free;
        res.crash_level = hit_max_next[7:5];
        res.sprite_done = pix_last;
      end
      S_UNDRAW: begin
        save_req.re     = 1'b1;
        save_req.addr   = u_idx;
        frame_req.we    = wr_pending;
        frame_req.addr  = wr_addr;
        frame_req.wdata = save_rdata;
      end
      S_DRAIN: begin
        frame_req.we    = 1'b1;
        frame_req.addr  = wr_addr;
        frame_req.wdata = save_rdata;
        res_valid       = slot_free;
        res.crash_level = hit_max[7:5];
        res.sprite_done = 1'b1;
      end
      S_DONE: begin
        res_valid       = slot_free;
        res.read_data   = (kind_q == KIND_READ) ? frame_rdata : 8'd0;
        res.crash_level = hit_max[7:5];
        res.sprite_done = done_q;
        res.error       = err_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      drawing      <= 1'b0;
      base_x       <= '0;
      row_cursor   <= '0;
      column_count <= '0;
      pixel_count  <= '0;
      size_w       <= '0;
      area         <= '0;
      hit_max      <= '0;
      shield_on    <= 1'b0;
      wr_pending   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q <= item.kind;
            pix_q  <= item.pixel;
            done_q <= 1'b0;
            err_q  <= 1'b0;
            unique case (item.kind)
              KIND_WRITE, KIND_READ: ;
              KIND_BEGIN: begin
                if (item_size_ok) begin
                  base_x       <= item.origin_x;
                  row_cursor   <= item.origin_y;
                  size_w       <= item.sprite_width;
                  area         <= 12'(item.sprite_width) * 12'(item.sprite_height);
                  shield_on    <= item.shield;
                  hit_max      <= '0;
                  column_count <= '0;
                  pixel_count  <= '0;
                  drawing      <= 1'b1;
                end else begin
                  err_q   <= 1'b1;
                  drawing <= 1'b0;
                end
              end
              KIND_PIXEL: begin
                pix_addr_q <= pix_addr;
                err_q      <= !pix_ok;
              end
              KIND_UNDRAW: begin
                if (item_size_ok) begin
                  u_row      <= item.origin_y;
                  u_x        <= item.origin_x;
                  u_w        <= item.sprite_width;
                  u_h        <= item.sprite_height;
                  u_col      <= '0;
                  u_rows     <= '0;
                  u_idx      <= '0;
                  wr_pending <= 1'b0;
                  drawing    <= 1'b0;
                end else begin
                  err_q <= 1'b1;
                end
              end
              default: err_q <= 1'b1;
            endcase
          end
        end
        S_PIX: begin
          hit_max     <= hit_max_next;
          pixel_count <= pixel_count + 11'd1;
          if (col_wrap) begin
            column_count <= '0;
            row_cursor   <= next_row(row_cursor);
          end else begin
            column_count <= column_count + 6'd1;
          end
          if (pix_last) begin
            drawing <= 1'b0;
          end
          done_q <= pix_last;
        end
        S_UNDRAW: begin
          // save read now, frame write of this entry in the next cycle
          wr_pending <= 1'b1;
          wr_addr    <= cell_addr(u_row, u_x, u_col);
          u_idx      <= u_idx + SAVE_AW'(1);
          if (u_col == u_w - 6'd1) begin
            u_col  <= '0;
            u_rows <= u_rows + 6'd1;
            u_row  <= next_row(u_row);
          end else begin
            u_col <= u_col + 6'd1;
          end
        end
        S_DRAIN: begin
          wr_pending <= 1'b0;
          done_q     <= 1'b1;
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/transparent_sprite_blitter_top.sv -----
// write, read, begin draw, rejected requests: the result goes from S_DONE into the output register
// sprite pixel: the frame memory read then write of the covered byte, then the output register
// undraw: restores width*height save buffer entries, one per cycle, the last one in S_DRAIN
// one request in flight; the output register lets the next request in while a result waits
// rst (synchronous) ends any draw and clears collision; memories keep their contents
module transparent_sprite_blitter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      kind,
  input  logic [tsb_pkg::FRAME_AW-1:0]    address,
  input  logic [8:0]                      origin_x,
  input  logic [7:0]                      origin_y,
  input  logic [5:0]                      sprite_width,
  input  logic [5:0]                      sprite_height,
  input  logic [7:0]                      pixel,
  input  logic                            shield,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      read_data,
  output logic [2:0]                      crash_level,
  output logic                            sprite_done,
  output logic                            error
);
  import tsb_pkg::*;

  item_t      item;
  result_t    res;
  logic       res_valid;
  logic       slot_free;
  frame_req_t frame_req;
  save_req_t  save_req;
  logic [7:0] frame_rdata;
  logic [7:0] save_rdata;

  assign item.kind          = kind;
  assign item.address       = address;
  assign item.origin_x      = origin_x;
  assign item.origin_y      = origin_y;
  assign item.sprite_width  = sprite_width;
  assign item.sprite_height = sprite_height;
  assign item.pixel         = pixel;
  assign item.shield        = shield;

  assign slot_free = !out_valid || !out_stall;

  tsb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .item        (item),
    .slot_free   (slot_free),
    .res_valid   (res_valid),
    .res         (res),
    .frame_req   (frame_req),
    .frame_rdata (frame_rdata),
    .save_req    (save_req),
    .save_rdata  (save_rdata)
  );

  tsb_frame_ram u_frame (
    .clk   (clk),
    .req   (frame_req),
    .rdata (frame_rdata)
  );

  tsb_save_ram u_save (
    .clk   (clk),
    .req   (save_req),
    .rdata (save_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      read_data   <= res.read_data;
      crash_level <= res.crash_level;
      sprite_done <= res.sprite_done;
      error       <= res.error;
    end
  end

endmodule

// ----- hw/rtl/tsb_checker.sv -----
module tsb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [2:0]                   kind,
  input logic [tsb_pkg::FRAME_AW-1:0] address,
  input logic [8:0]                   origin_x,
  input logic [7:0]                   origin_y,
  input logic [5:0]                   sprite_width,
  input logic [5:0]                   sprite_height,
  input logic [7:0]                   pixel,
  input logic                         shield,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [7:0]                   read_data,
  input logic [2:0]                   crash_level,
  input logic                         sprite_done,
  input logic                         error
);

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one in flight");

  a_done_err_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(sprite_done && error))
    else $error("sprite_done and error both set");

  // only a plain read returns data
  a_read_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != 8'd0) |-> !sprite_done && !error)
    else $error("read data on a non-read result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) &&
      $stable(crash_level) && $stable(sprite_done) && $stable(error))
    else $error("stalled result changed");

endmodule

bind transparent_sprite_blitter_top tsb_checker u_tsb_checker (.*);

// ----- verif/transparent_sprite_blitter_top_tb.sv -----
`timescale 1ns / 100ps

module transparent_sprite_blitter_top_tb;
  import tsb_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int STUCK_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 1100;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [2:0] KIND_BAD_FIRST = 3'd5;
  localparam logic [2:0] KIND_BAD_LAST  = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    item_t   req;
    result_t resp;
  } blit_req_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          kind = '0;
  logic [FRAME_AW-1:0] address = '0;
  logic [8:0]          origin_x = '0;
  logic [7:0]          origin_y = '0;
  logic [5:0]          sprite_width = '0;
  logic [5:0]          sprite_height = '0;
  logic [7:0]          pixel = '0;
  logic                shield = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          read_data;
  logic [2:0]          crash_level;
  logic                sprite_done;
  logic                error;

  transparent_sprite_blitter_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .address       (address),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .pixel         (pixel),
    .shield        (shield),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .crash_level   (crash_level),
    .sprite_done   (sprite_done),
    .error         (error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // shadow of the blitter: frame, save buffer and draw registers
  logic [7:0]  fb_mem [FRAME_BYTES];
  bit          fb_known [FRAME_BYTES];
  logic [7:0]  save_mem [SAVE_DEPTH];
  int          save_filled = 0;
  int unsigned known_addrs [$];
  logic [8:0]  base_x = '0;
  logic [7:0]  row_at = '0;
  logic [5:0]  col_at = '0;
  logic [10:0] pix_count = '0;
  logic [5:0]  span_w = '0;
  logic [5:0]  span_h = '0;
  logic [7:0]  hit_max = '0;
  logic        shield_on = 1'b0;
  logic        draw_on = 1'b0;

  blit_req_t pending_reqs [$];
  result_t   due_results [$];
  result_t   offered_resp;
  int        queued_count = 0;
  int        mismatches = 0;
  int        results_seen = 0;
  bit        in_fire = 1'b0;
  bit        out_fire = 1'b0;

  function automatic logic [FRAME_AW-1:0] frame_index(input logic [7:0] row,
                                                      input logic [8:0] x,
                                                      input logic [5:0] col);
    int unsigned s;
    s = int'(row) * STRIDE_BYTES + int'(x) + int'(col);
    return FRAME_AW'(s % FRAME_BYTES);
  endfunction

  function automatic logic [7:0] step_row(input logic [7:0] row);
    return (int'(row) >= ROWS - 1) ? 8'd0 : row + 8'd1;
  endfunction

  function automatic bit span_ok(input logic [5:0] w, input logic [5:0] h);
    return w != 0 && h != 0 && w <= MAX_SPRITE && h <= MAX_SPRITE &&
           int'(w) * int'(h) <= SAVE_DEPTH;
  endfunction

  function automatic void frame_store(input logic [FRAME_AW-1:0] a, input logic [7:0] v);
    fb_mem[a] = v;
    if (!fb_known[a]) begin
      fb_known[a] = 1'b1;
      known_addrs.push_back(32'(a));
    end
  endfunction

  function automatic result_t frame_apply(input item_t it);
    result_t r;
    logic [FRAME_AW-1:0] a;
    logic [7:0] under;
    logic [7:0] row;
    int n;
    r = '0;
    case (it.kind)
      KIND_WRITE: frame_store(it.address, it.pixel);
      KIND_READ: r.read_data = fb_mem[it.address];
      KIND_BEGIN: begin
        if (!span_ok(it.sprite_width, it.sprite_height)) begin
          r.error = 1'b1;
          draw_on = 1'b0;
        end else begin
          base_x = it.origin_x;
          row_at = it.origin_y;
          span_w = it.sprite_width;
          span_h = it.sprite_height;
          shield_on = it.shield;
          hit_max = '0;
          col_at = '0;
          pix_count = '0;
          draw_on = 1'b1;
        end
      end
      KIND_PIXEL: begin
        if (!draw_on || pix_count >= SAVE_DEPTH) begin
          r.error = 1'b1;
        end else begin
          a = frame_index(row_at, base_x, col_at);
          under = fb_mem[a];
          save_mem[pix_count[SAVE_AW-1:0]] = under;
          if (it.pixel != 0) begin
            if (under > hit_max && (!shield_on || under < SHIELD_LIMIT)) hit_max = under;
            frame_store(a, it.pixel);
          end
          pix_count++;
          col_at++;
          if (col_at >= span_w) begin
            col_at = '0;
            row_at = step_row(row_at);
          end
          if (pix_count >= 11'(span_w) * 11'(span_h)) begin
            draw_on = 1'b0;
            r.sprite_done = 1'b1;
          end
          if (int'(pix_count) > save_filled) save_filled = int'(pix_count);
        end
      end
      KIND_UNDRAW: begin
        if (!span_ok(it.sprite_width, it.sprite_height)) begin
          r.error = 1'b1;
        end else begin
          row = it.origin_y;
          n = 0;
          for (int ry = 0; ry < it.sprite_height; ry++) begin
            for (int cx = 0; cx < it.sprite_width; cx++) begin
              frame_store(frame_index(row, it.origin_x, 6'(cx)), save_mem[n % SAVE_DEPTH]);
              n++;
            end
            row = step_row(row);
          end
          draw_on = 1'b0;
          r.sprite_done = 1'b1;
        end
      end
      default: r.error = 1'b1;
    endcase
    r.crash_level = hit_max[7:5];
    return r;
  endfunction

  // expectation is worked out in issue order, which is also acceptance order
  function automatic void queue_req(input item_t it);
    blit_req_t br;
    br.req = it;
    br.resp = frame_apply(it);
    pending_reqs.push_back(br);
    queued_count++;
  endfunction

  function automatic item_t random_req();
    item_t it;
    it.kind = 3'($urandom_range(0, 7));
    it.address = FRAME_AW'($urandom_range(0, FRAME_BYTES - 1));
    it.origin_x = 9'($urandom_range(0, 511));
    it.origin_y = 8'($urandom_range(0, 255));
    it.sprite_width = 6'($urandom_range(0, 63));
    it.sprite_height = 6'($urandom_range(0, 63));
    it.pixel = 8'($urandom_range(0, 255));
    it.shield = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // zeros and shield-range bytes show up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0, 1, 2: return 8'd0;
      3, 4, 5, 6, 7: return 8'($urandom_range(224, 255));
      default: return 8'($urandom_range(1, 223));
    endcase
  endfunction

  function automatic logic [5:0] pick_span();
    case ($urandom_range(0, 19))
      0: return 6'($urandom_range(13, 32));
      1, 2, 3, 4, 5: return 6'($urandom_range(5, 12));
      default: return 6'($urandom_range(1, 4));
    endcase
  endfunction

  // hot spots near the row start and end and the frame wrap keep prefill cheap
  function automatic logic [8:0] pick_origin_x();
    case ($urandom_range(0, 4))
      0, 1: return 9'($urandom_range(0, 15));
      2, 3: return 9'($urandom_range(496, 511));
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [7:0] pick_origin_y();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(252, 255));
      4, 5, 6: return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_write(input int unsigned a, input logic [7:0] v);
    item_t it;
    it = random_req();
    it.kind = KIND_WRITE;
    it.address = FRAME_AW'(a);
    it.pixel = v;
    queue_req(it);
  endfunction

  function automatic void queue_read(input int unsigned a);
    item_t it;
    it = random_req();
    it.kind = KIND_READ;
    it.address = FRAME_AW'(a);
    queue_req(it);
  endfunction

  function automatic void queue_begin(input logic [8:0] ox, input logic [7:0] oy,
                                      input logic [5:0] w, input logic [5:0] h,
                                      input logic shd);
    item_t it;
    it = random_req();
    it.kind = KIND_BEGIN;
    it.origin_x = ox;
    it.origin_y = oy;
    it.sprite_width = w;
    it.sprite_height = h;
    it.shield = shd;
    queue_req(it);
  endfunction

  function automatic void queue_undraw(input logic [8:0] ox, input logic [7:0] oy,
                                       input logic [5:0] w, input logic [5:0] h);
    item_t it;
    it = random_req();
    it.kind = KIND_UNDRAW;
    it.origin_x = ox;
    it.origin_y = oy;
    it.sprite_width = w;
    it.sprite_height = h;
    queue_req(it);
  endfunction

  // the covered byte gets written first if it was never written
  function automatic void queue_pixel(input logic [7:0] pix);
    item_t it;
    logic [FRAME_AW-1:0] a;
    if (draw_on) begin
      a = frame_index(row_at, base_x, col_at);
      if (!fb_known[a]) queue_write(32'(a), pick_byte());
    end
    it = random_req();
    it.kind = KIND_PIXEL;
    it.pixel = pix;
    queue_req(it);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
  endtask

  // sender: bursts of requests with random gaps
  blit_req_t nxt_req;
  int        burst_left = 1;
  int        gap_left = 0;

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (gap_left != 0 || pending_reqs.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        nxt_req = pending_reqs.pop_front();
        kind          <= nxt_req.req.kind;
        address       <= nxt_req.req.address;
        origin_x      <= nxt_req.req.origin_x;
        origin_y      <= nxt_req.req.origin_y;
        sprite_width  <= nxt_req.req.sprite_width;
        sprite_height <= nxt_req.req.sprite_height;
        pixel         <= nxt_req.req.pixel;
        shield        <= nxt_req.req.shield;
        offered_resp = nxt_req.resp;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: stall pattern changes now and then, plus one long hold-off
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (mode_left % 5 < 2);
        endcase
      end
    end
  end

  result_t want;
  int      stuck = 0;

  always @(posedge clk) begin
    if (!rst) begin
      in_fire = in_valid && !in_stall;
      out_fire = out_valid && !out_stall;
      if (out_fire) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, read_data);
            mismatches++;
          end
          if (crash_level !== want.crash_level) begin
            $error("crash_level: expected %0d, got %0d", want.crash_level, crash_level);
            mismatches++;
          end
          if (sprite_done !== want.sprite_done) begin
            $error("sprite_done: expected %0d, got %0d", want.sprite_done, sprite_done);
            mismatches++;
          end
          if (error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, error);
            mismatches++;
          end
        end
      end
      if (in_fire) due_results.push_back(offered_resp);
      if (in_fire || out_fire) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= STUCK_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    item_t       it;
    logic [8:0]  ox;
    logic [7:0]  oy;
    logic [5:0]  sw;
    logic [5:0]  sh;
    int          area;
    int          cut;
    int          lim;
    int          pick;
    int          iter;
    bit          big;
    bit          paused;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_write(0, 8'd0);
    queue_write(FRAME_BYTES - 1, 8'hFF);
    queue_read(FRAME_BYTES - 1);
    queue_read(0);
    queue_pixel(8'h55);
    for (int k = KIND_BAD_FIRST; k <= KIND_BAD_LAST; k++) begin
      it = random_req();
      it.kind = 3'(k);
      queue_req(it);
    end
    queue_begin(9'd7, 8'd3, 6'd1, 6'd1, 1'b0);
    queue_begin(9'd0, 8'd0, 6'd0, 6'd5, 1'b0);
    queue_pixel(8'd1);
    queue_begin(9'd0, 8'd0, 6'd4, 6'd63, 1'b0);
    queue_undraw(9'd0, 8'd0, 6'd33, 6'd1);
    queue_begin(9'd511, 8'd255, 6'd32, 6'd32, 1'b1);
    // new begin replaces the full-size one; spills past the row end and wraps to row 0
    queue_write(32'(frame_index(8'd255, 9'd510, 6'd0)), 8'd240);
    queue_write(32'(frame_index(8'd255, 9'd510, 6'd1)), 8'd100);
    queue_begin(9'd510, 8'd255, 6'd3, 6'd2, 1'b1);
    queue_pixel(8'd255);
    queue_pixel(8'd1);
    queue_pixel(8'd0);
    queue_pixel(8'd224);
    queue_pixel(8'd128);
    queue_pixel(8'd7);
    queue_pixel(8'd9);
    queue_read(32'(frame_index(8'd255, 9'd510, 6'd0)));
    queue_undraw(9'd510, 8'd255, 6'd3, 6'd2);
    queue_read(32'(frame_index(8'd255, 9'd510, 6'd0)));

    queued_count = 0;
    iter = 0;
    paused = 1'b0;
    while (queued_count < RANDOM_ITEMS) begin
      if (!paused && queued_count >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_idle();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55 || iter == 3) begin
        big = (iter == 3) || ($urandom_range(0, 199) == 0);
        sw = big ? 6'd32 : pick_span();
        sh = big ? 6'd32 : pick_span();
        ox = pick_origin_x();
        oy = pick_origin_y();
        queue_begin(ox, oy, sw, sh, 1'($urandom_range(0, 1)));
        area = int'(sw) * int'(sh);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, area - 1) : area;
        for (int p = 0; p < cut; p++) begin
          if ($urandom_range(0, 24) == 0)
            queue_write($urandom_range(0, FRAME_BYTES - 1), pick_byte());
          queue_pixel(($urandom_range(0, 3) == 0) ? 8'd0 : pick_byte());
        end
        if (cut == area) begin
          if ($urandom_range(0, 7) == 0) queue_pixel(pick_byte());
          if ($urandom_range(0, 2) != 0) queue_undraw(ox, oy, sw, sh);
        end
      end else if (pick < 68) begin
        // restore only what the save buffer already holds
        if (save_filled > 0) begin
          lim = (save_filled < MAX_SPRITE) ? save_filled : MAX_SPRITE;
          sw = 6'($urandom_range(1, lim));
          lim = save_filled / int'(sw);
          if (lim > MAX_SPRITE) lim = MAX_SPRITE;
          sh = 6'($urandom_range(1, lim));
          queue_undraw(pick_origin_x(), pick_origin_y(), sw, sh);
        end
      end else if (pick < 82) begin
        queue_write($urandom_range(0, FRAME_BYTES - 1), pick_byte());
      end else if (pick < 93) begin
        if (known_addrs.size() != 0)
          queue_read(known_addrs[$urandom_range(0, known_addrs.size() - 1)]);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            it = random_req();
            it.kind = 3'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
            queue_req(it);
          end
          1: queue_begin(pick_origin_x(), pick_origin_y(),
                         $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63)),
                         6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
          2: queue_pixel(pick_byte());
          default: queue_undraw(pick_origin_x(), pick_origin_y(),
                                6'($urandom_range(0, 63)), 6'($urandom_range(33, 63)));
        endcase
      end
      iter++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
